>>> src/sxd_pkg.sv
package sxd_pkg;

   // fixed field widths
   localparam int WIN_REG_W  = 11;
   localparam int TAU_W      = 16;
   localparam int SEL_REG_W  = 11;
   localparam int DELAY_W    = 12;
   localparam int VALUE_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int Q_W        = 17;
   localparam int NST_W      = 5;

   // register reset values
   localparam logic [WIN_REG_W-1:0] WIN_RESET = 11'd256;
   localparam logic [TAU_W-1:0]     TAU_RESET = 16'd655;
   localparam logic [SEL_REG_W-1:0] SEL_RESET = 11'd256;

   // normalize divider: load, integer step, 15 fraction steps, rounding step
   localparam logic [NST_W-1:0] NST_LOAD  = 5'd0;
   localparam logic [NST_W-1:0] NST_FIRST = 5'd1;
   localparam logic [NST_W-1:0] NST_LAST  = 5'd17;

   localparam logic [VALUE_W-1:0] VALUE_POS_MAX = 16'h7fff;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW = 2'd0,
      REG_TAU    = 2'd1,
      REG_SELECT = 2'd2,
      REG_BYPASS = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      RES_BEST   = 2'd0,
      RES_WORST  = 2'd1,
      RES_CHOSEN = 2'd2
   } res_sel_type;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_AREAD  = 8'b0000_0100,
      S_LAGS   = 8'b0000_1000,
      S_HWRITE = 8'b0001_0000,
      S_SCAN   = 8'b0010_0000,
      S_NORM   = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

endpackage

>>> src/sxd_if.sv
// request channel: sample pair and control
interface sxd_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic signed [SAMPLE_BITS-1:0] sample_a;
   logic signed [SAMPLE_BITS-1:0] sample_b;
   logic                          end_of_block;

   modport source (output valid, op, sample_a, sample_b, end_of_block, input ready);
   modport sink   (input valid, op, sample_a, sample_b, end_of_block, output ready);
endinterface

// response channel: delay report
interface sxd_rsp_if import sxd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DELAY_W-1:0] best_delay;
   logic signed [VALUE_W-1:0] best_value;
   logic signed [DELAY_W-1:0] worst_delay;
   logic signed [VALUE_W-1:0] worst_value;
   logic signed [DELAY_W-1:0] chosen_delay;
   logic signed [VALUE_W-1:0] chosen_value;

   modport source (output valid, best_delay, best_value, worst_delay, worst_value,
                   chosen_delay, chosen_value, input ready);
   modport sink   (input valid, best_delay, best_value, worst_delay, worst_value,
                   chosen_delay, chosen_value, output ready);
endinterface

// register write channel
interface sxd_csr_if import sxd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/smoothed_xcorr_delay_finder.sv
// Push item: one lag per cycle (N = effective window, 2N lags) through
//   the shared multiply/accumulate pipeline over the correlation memories.
// End of block adds a scan over all 2N lags and 3 x 18 divider steps before the report.
// Clear (reset, clear op, window change, bypass on): sweeps 4*MAX_WINDOW history entries, one
//   per cycle, during which req is not ready; register writes are taken as ever.
// Reset is synchronous, active high; it restores register defaults and starts a clear.
module smoothed_xcorr_delay_finder import sxd_pkg::*; #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic   clock,
   input  logic   reset,
   sxd_req_if.sink   req_chan,
   sxd_rsp_if.source rsp_chan,
   sxd_csr_if.sink   csr_chan
);

   localparam int HIST_DEPTH = 4 * MAX_WINDOW;
   localparam int HW         = $clog2(HIST_DEPTH);
   localparam int LAG_DEPTH  = 2 * MAX_WINDOW;
   localparam int LW         = $clog2(LAG_DEPTH);
   localparam int NW         = $clog2(MAX_WINDOW) + 1;
   localparam int PW         = 2 * SAMPLE_BITS;
   localparam int CW         = 2 * SAMPLE_BITS + $clog2(MAX_WINDOW) + 2;
   localparam int PRW        = CW + TAU_W + 2;

   function automatic logic [NW-1:0] eff_window(input logic [WIN_REG_W-1:0] w);
      logic [31:0] t;
      t = 32'(w);
      if (t > 32'(MAX_WINDOW)) t = 32'(MAX_WINDOW);
      t = t & ~32'd3;
      if (t < 32'd4) t = 32'd4;
      return NW'(t);
   endfunction

   // control registers
   state_type            state_ff, state_in;
   logic [HW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [HW-1:0]        wp_ff, wp_in;
   logic [LW:0]          iss_ff, iss_in;
   logic                 pend_ff, pend_in;
   logic                 zero_ff, zero_in;
   logic                 eob_ff, eob_in;
   logic [1:0]           nk_ff, nk_in;
   logic [NST_W-1:0]     nst_ff, nst_in;
   logic [WIN_REG_W-1:0] win_ff, win_in;
   logic [TAU_W-1:0]     tau_ff, tau_in;
   logic [SEL_REG_W-1:0] sel_ff, sel_in;
   logic                 byp_ff, byp_in;
   logic                 iss_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic                 rsp_vld_ff, rsp_vld_in;

   // payload registers
   logic signed [SAMPLE_BITS-1:0] a_smp_ff, b_smp_ff;
   logic [LW-1:0]                 iss_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic signed [SAMPLE_BITS-1:0] a_rd0_ff, a_rd1_ff, b_rd0_ff, b_rd1_ff;
   logic signed [CW-1:0]          run_rd_ff, sm_rd_ff;
   logic signed [PW-1:0]          p_add_ff, p_sub_ff;
   logic signed [CW-1:0]          run_s2_ff, sm_s2_ff, sm_s3_ff, sm_s4_ff;
   logic signed [CW:0]            diff_ff;
   logic signed [PRW-1:0]         prod_ff;
   logic signed [CW-1:0]          best_v_ff, worst_v_ff, sel_v_ff;
   logic [LW-1:0]                 best_i_ff, worst_i_ff;
   logic [CW-1:0]                 mag_max_ff, rem_ff;
   logic [Q_W-1:0]                q_ff;
   logic                          neg_ff;
   logic signed [VALUE_W-1:0]     res_val_ff [3];
   logic signed [DELAY_W-1:0]     o_bd_ff, o_wd_ff, o_cd_ff;
   logic signed [VALUE_W-1:0]     o_bv_ff, o_wv_ff, o_cv_ff;

   // stores
   logic signed [SAMPLE_BITS-1:0] a_mem   [HIST_DEPTH];
   logic signed [SAMPLE_BITS-1:0] b_mem   [HIST_DEPTH];
   logic signed [CW-1:0]          run_mem [LAG_DEPTH];
   logic signed [CW-1:0]          sm_mem  [LAG_DEPTH];

   // combinational
   logic [NW-1:0]            n_win;
   logic [LW:0]              f_cnt;
   logic [LW-1:0]            f_last, sel_lag;
   logic [HW-1:0]            n_h, n2_h, n3_h, lag_h;
   logic [HW-1:0]            a_ra0, a_ra1, b_ra0, b_ra1, h_wa;
   logic signed [SAMPLE_BITS-1:0] a_wd, b_wd;
   logic [LW-1:0]            lag_wa_run, lag_wa_sm;
   logic signed [CW-1:0]     run_wd, sm_wd, run_new, sm_new, scan_v, norm_v;
   logic signed [PRW-1:0]    stp;
   logic [CW-1:0]            scan_mag, norm_mag, rem_sh;
   logic [Q_W-1:0]           q_fin;
   logic signed [VALUE_W-1:0] norm_res;
   logic                     clearing, h_we, run_we, sm_we, issuing, pipe_busy;
   logic                     req_acc, csr_acc, rsp_load;
   logic [NW-1:0]            n_new;

   // window, lag count and selected lag
   assign n_win   = eff_window(win_ff);
   assign f_cnt   = (LW+1)'({n_win, 1'b0});
   assign f_last  = LW'(f_cnt - (LW+1)'(1));
   assign sel_lag = (32'(sel_ff) > 32'(f_last)) ? f_last : LW'(sel_ff);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_acc        = csr_chan.valid;
   assign n_new          = eff_window(csr_chan.data[WIN_REG_W-1:0]);

   assign issuing   = ((state_ff == S_LAGS) || (state_ff == S_SCAN)) && (iss_ff < f_cnt);
   assign pipe_busy = issuing || iss_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff;
   assign clearing  = (state_ff == S_CLEAR);

   // history ring addresses, all modulo the ring depth
   assign n_h   = HW'(n_win);
   assign n2_h  = HW'({n_win, 1'b0});
   assign n3_h  = n2_h + n_h;
   assign lag_h = HW'(iss_ff[LW-1:0]);
   assign a_ra0 = wp_ff - n_h;
   assign a_ra1 = wp_ff - n2_h;
   assign b_ra0 = wp_ff - n2_h + lag_h;
   assign b_ra1 = wp_ff - n3_h + lag_h;

   // store write ports: clear sweep or normal update
   assign h_we       = clearing || (state_ff == S_HWRITE);
   assign h_wa       = clearing ? clr_cnt_ff : wp_ff;
   assign a_wd       = clearing ? '0 : a_smp_ff;
   assign b_wd       = clearing ? '0 : b_smp_ff;
   assign run_new    = run_s2_ff + CW'(p_add_ff) - CW'(p_sub_ff);
   assign stp        = (prod_ff + signed'(PRW'(32768))) >>> 16;
   assign sm_new     = sm_s4_ff + CW'(stp);
   assign run_we     = clearing || s2_vld_ff;
   assign lag_wa_run = clearing ? clr_cnt_ff[LW-1:0] : s2_idx_ff;
   assign run_wd     = clearing ? '0 : run_new;
   assign sm_we      = clearing || s4_vld_ff;
   assign lag_wa_sm  = clearing ? clr_cnt_ff[LW-1:0] : s4_idx_ff;
   assign sm_wd      = clearing ? '0 : sm_new;

   // memories with registered reads
   always_ff @(posedge clock) begin
      if (h_we) begin
         a_mem[h_wa] <= a_wd;
         b_mem[h_wa] <= b_wd;
      end
      a_rd0_ff <= a_mem[a_ra0];
      a_rd1_ff <= a_mem[a_ra1];
      b_rd0_ff <= b_mem[b_ra0];
      b_rd1_ff <= b_mem[b_ra1];
   end

   always_ff @(posedge clock) begin
      if (run_we) run_mem[lag_wa_run] <= run_wd;
      run_rd_ff <= run_mem[iss_ff[LW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sm_we) sm_mem[lag_wa_sm] <= sm_wd;
      sm_rd_ff <= sm_mem[iss_ff[LW-1:0]];
   end

   // lag update pipeline: products, running sum, smoothing product, smoothed sum
   always_ff @(posedge clock) begin
      iss_idx_ff <= iss_ff[LW-1:0];
      p_add_ff   <= a_rd0_ff * b_rd0_ff;
      p_sub_ff   <= a_rd1_ff * b_rd1_ff;
      run_s2_ff  <= run_rd_ff;
      sm_s2_ff   <= sm_rd_ff;
      s2_idx_ff  <= iss_idx_ff;
      diff_ff    <= (CW+1)'(run_new) - (CW+1)'(sm_s2_ff);
      sm_s3_ff   <= sm_s2_ff;
      s3_idx_ff  <= s2_idx_ff;
      prod_ff    <= diff_ff * signed'({1'b0, tau_ff});
      sm_s4_ff   <= sm_s3_ff;
      s4_idx_ff  <= s3_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_vld_ff <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
      end else begin
         iss_vld_ff <= issuing;
         s2_vld_ff  <= iss_vld_ff && (state_ff == S_LAGS);
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
      end
   end

   // scan for max, min, selected lag and largest magnitude
   assign scan_v   = sm_rd_ff;
   assign scan_mag = scan_v[CW-1] ? CW'(-scan_v) : CW'(scan_v);

   always_ff @(posedge clock) begin
      if (iss_vld_ff && (state_ff == S_SCAN)) begin
         if (iss_idx_ff == '0) begin
            best_v_ff  <= scan_v;
            best_i_ff  <= '0;
            worst_v_ff <= scan_v;
            worst_i_ff <= '0;
            mag_max_ff <= scan_mag;
         end else begin
            if (scan_v > best_v_ff) begin
               best_v_ff <= scan_v;
               best_i_ff <= iss_idx_ff;
            end
            if (scan_v < worst_v_ff) begin
               worst_v_ff <= scan_v;
               worst_i_ff <= iss_idx_ff;
            end
            if (scan_mag > mag_max_ff) mag_max_ff <= scan_mag;
         end
         if (iss_idx_ff == sel_lag) sel_v_ff <= scan_v;
      end
   end

   // shared restoring divider: one quotient bit per cycle
   always_comb begin
      unique case (res_sel_type'(nk_ff))
         RES_BEST:   norm_v = best_v_ff;
         RES_WORST:  norm_v = worst_v_ff;
         RES_CHOSEN: norm_v = sel_v_ff;
         default:    norm_v = sel_v_ff;
      endcase
   end
   assign norm_mag = norm_v[CW-1] ? CW'(-norm_v) : CW'(norm_v);
   assign rem_sh   = {rem_ff[CW-2:0], 1'b0};
   assign q_fin    = q_ff + Q_W'(rem_sh >= mag_max_ff);
   always_comb begin
      if (mag_max_ff == '0)              norm_res = '0;
      else if (neg_ff)                   norm_res = VALUE_W'(-q_fin);
      else if (q_fin > Q_W'(VALUE_POS_MAX)) norm_res = VALUE_POS_MAX;
      else                               norm_res = VALUE_W'(q_fin);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_NORM) begin
         if (nst_ff == NST_LOAD) begin
            rem_ff <= norm_mag;
            q_ff   <= '0;
            neg_ff <= norm_v[CW-1];
         end else if (nst_ff == NST_FIRST) begin
            if (rem_ff >= mag_max_ff) begin
               q_ff   <= Q_W'(1);
               rem_ff <= rem_ff - mag_max_ff;
            end
         end else if (nst_ff == NST_LAST) begin
            res_val_ff[nk_ff] <= norm_res;
         end else begin
            if (rem_sh >= mag_max_ff) begin
               q_ff   <= {q_ff[Q_W-2:0], 1'b1};
               rem_ff <= rem_sh - mag_max_ff;
            end else begin
               q_ff   <= {q_ff[Q_W-2:0], 1'b0};
               rem_ff <= rem_sh;
            end
         end
      end
   end

   // sample capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_smp_ff <= req_chan.sample_a;
         b_smp_ff <= req_chan.sample_b;
      end
   end

   // sequencer and register file
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      wp_in      = wp_ff;
      iss_in     = iss_ff;
      pend_in    = pend_ff;
      zero_in    = zero_ff;
      eob_in     = eob_ff;
      nk_in      = nk_ff;
      nst_in     = nst_ff;
      win_in     = win_ff;
      tau_in     = tau_ff;
      sel_in     = sel_ff;
      byp_in     = byp_ff;
      rsp_load   = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + HW'(1);
            if (clr_cnt_ff == HW'(HIST_DEPTH - 1)) begin
               state_in = pend_ff ? S_OUT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               eob_in = req_chan.end_of_block;
               if (req_chan.op) begin
                  pend_in    = req_chan.end_of_block;
                  zero_in    = 1'b1;
                  clr_cnt_in = '0;
                  wp_in      = '0;
                  state_in   = S_CLEAR;
               end else if (byp_ff) begin
                  zero_in = 1'b1;
                  if (req_chan.end_of_block) state_in = S_OUT;
               end else begin
                  zero_in  = 1'b0;
                  state_in = S_AREAD;
               end
            end
         end
         S_AREAD: begin
            iss_in   = '0;
            state_in = S_LAGS;
         end
         S_LAGS: begin
            if (issuing) iss_in = iss_ff + (LW+1)'(1);
            if (!pipe_busy) state_in = S_HWRITE;
         end
         S_HWRITE: begin
            wp_in = wp_ff + HW'(1);
            if (eob_ff) begin
               iss_in   = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (issuing) iss_in = iss_ff + (LW+1)'(1);
            if (!pipe_busy) begin
               nk_in    = 2'(RES_BEST);
               nst_in   = NST_LOAD;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (nst_ff == NST_LAST) begin
               nst_in = NST_LOAD;
               if (nk_ff == 2'(RES_CHOSEN)) state_in = S_OUT;
               else nk_in = nk_ff + 2'd1;
            end else begin
               nst_in = nst_ff + NST_W'(1);
            end
         end
         S_OUT: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               pend_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // register writes; a change of effective window or bypass turning on restarts the clear
      if (csr_acc) begin
         unique case (csr_reg_type'(csr_chan.index))
            REG_WINDOW: begin
               win_in = csr_chan.data[WIN_REG_W-1:0];
               if (n_new != n_win) begin
                  clr_cnt_in = '0;
                  wp_in      = '0;
                  state_in   = S_CLEAR;
               end
            end
            REG_TAU:    tau_in = csr_chan.data[TAU_W-1:0];
            REG_SELECT: sel_in = csr_chan.data[SEL_REG_W-1:0];
            REG_BYPASS: begin
               byp_in = csr_chan.data[0];
               if (csr_chan.data[0] && !byp_ff) begin
                  clr_cnt_in = '0;
                  wp_in      = '0;
                  state_in   = S_CLEAR;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rsp_load)            rsp_vld_in = 1'b1;
      else if (rsp_chan.ready) rsp_vld_in = 1'b0;
      else                     rsp_vld_in = rsp_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         wp_ff      <= '0;
         iss_ff     <= '0;
         pend_ff    <= 1'b0;
         zero_ff    <= 1'b0;
         eob_ff     <= 1'b0;
         nk_ff      <= '0;
         nst_ff     <= NST_LOAD;
         win_ff     <= WIN_RESET;
         tau_ff     <= TAU_RESET;
         sel_ff     <= SEL_RESET;
         byp_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         wp_ff      <= wp_in;
         iss_ff     <= iss_in;
         pend_ff    <= pend_in;
         zero_ff    <= zero_in;
         eob_ff     <= eob_in;
         nk_ff      <= nk_in;
         nst_ff     <= nst_in;
         win_ff     <= win_in;
         tau_ff     <= tau_in;
         sel_ff     <= sel_in;
         byp_ff     <= byp_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (zero_ff) begin
            o_bd_ff <= '0;
            o_bv_ff <= '0;
            o_wd_ff <= '0;
            o_wv_ff <= '0;
            o_cd_ff <= '0;
            o_cv_ff <= '0;
         end else begin
            o_bd_ff <= DELAY_W'(32'(n_win) - 32'(best_i_ff));
            o_bv_ff <= res_val_ff[RES_BEST];
            o_wd_ff <= DELAY_W'(32'(n_win) - 32'(worst_i_ff));
            o_wv_ff <= res_val_ff[RES_WORST];
            o_cd_ff <= DELAY_W'(32'(n_win) - 32'(sel_lag));
            o_cv_ff <= res_val_ff[RES_CHOSEN];
         end
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.best_delay   = o_bd_ff;
   assign rsp_chan.best_value   = o_bv_ff;
   assign rsp_chan.worst_delay  = o_wd_ff;
   assign rsp_chan.worst_value  = o_wv_ff;
   assign rsp_chan.chosen_delay = o_cd_ff;
   assign rsp_chan.chosen_value = o_cv_ff;

endmodule

>>> src/sxd_checker.sv
module sxd_checker import sxd_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_op,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_best_value,
   input logic signed [DELAY_W-1:0] rsp_chosen_delay
);

   // a pending report stays offered
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   // and its best value and chosen delay hold
   rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_best_value) && $stable(rsp_chosen_delay))
      else $error("rsp payload changed while stalled");

   // reset starts the clearing sweep with no report pending
   reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block not busy or report pending after reset");

   // a clear transfer makes the block busy
   clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op |=> !req_ready)
      else $error("ready after clear transfer");

endmodule

bind smoothed_xcorr_delay_finder sxd_checker u_sxd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_op           (req_chan.op),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_best_value   (rsp_chan.best_value),
   .rsp_chosen_delay (rsp_chan.chosen_delay)
);

>>> tb/smoothed_xcorr_delay_finder_test.sv
`timescale 1ns / 1ps

module smoothed_xcorr_delay_finder_test;
   import sxd_pkg::*;

   localparam int MAX_WIN    = 1024;
   localparam int HIST_LEN   = 4 * MAX_WIN;
   localparam int LAG_LEN    = 2 * MAX_WIN;
   localparam int CYCLE_CAP  = 1500000;

   typedef struct {
      logic signed [DELAY_W-1:0] best_delay;
      logic signed [VALUE_W-1:0] best_value;
      logic signed [DELAY_W-1:0] worst_delay;
      logic signed [VALUE_W-1:0] worst_value;
      logic signed [DELAY_W-1:0] chosen_delay;
      logic signed [VALUE_W-1:0] chosen_value;
   } delay_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sxd_req_if #(.SAMPLE_BITS(16)) req_chan ();
   sxd_rsp_if rsp_chan ();
   sxd_csr_if csr_chan ();

   smoothed_xcorr_delay_finder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // mirrored registers and correlation stores
   logic [WIN_REG_W-1:0] win_reg;
   logic [TAU_W-1:0]     tau_reg;
   logic [SEL_REG_W-1:0] sel_reg;
   logic                 bypass_reg;
   longint               a_ring [HIST_LEN];
   longint               b_ring [HIST_LEN];
   longint               corr_sum [LAG_LEN];
   longint               corr_avg [LAG_LEN];
   int unsigned          ring_pos;

   delay_report_type reports_due [$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            burst_left = 0;
   int            hold_request = 0;
   int            hold_left = 0;
   int            stall_mode = 0;
   logic [15:0]   a_trail [64];

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int unsigned window_of(logic [WIN_REG_W-1:0] w);
      int unsigned n;
      n = (w > MAX_WIN) ? MAX_WIN : w;
      n = n & ~32'd3;
      if (n < 4) n = 4;
      return n;
   endfunction

   function automatic int unsigned ring_back(int unsigned k);
      return (ring_pos + HIST_LEN - k) % HIST_LEN;
   endfunction

   task automatic wipe_stores();
      for (int i = 0; i < HIST_LEN; i++) begin
         a_ring[i] = 0;
         b_ring[i] = 0;
      end
      for (int i = 0; i < LAG_LEN; i++) begin
         corr_sum[i] = 0;
         corr_avg[i] = 0;
      end
      ring_pos = 0;
   endtask

   // rounded (d * tau) / 2^16 with the low 16 bits handled apart
   function automatic longint smooth_step(longint d, longint tau);
      longint lo, hi;
      lo = d & 64'hFFFF;
      hi = (d - lo) >>> 16;
      return hi * tau + ((lo * tau + 32768) >>> 16);
   endfunction

   // restoring division |v| * 2^15 / peak, rounded half up, saturated
   function automatic longint scale_to_peak(longint v, longint unsigned peak);
      longint unsigned r, q;
      if (peak == 0) return 0;
      q = 0;
      r = (v < 0) ? longint'(-v) : longint'(v);
      if (r >= peak) begin
         q = 1;
         r -= peak;
      end
      for (int i = 0; i < 15; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= peak) begin
            q |= 1;
            r -= peak;
         end
      end
      r = r << 1;
      if (r >= peak) q++;
      if (v < 0) return -longint'(q);
      return (q > 32767) ? 32767 : longint'(q);
   endfunction

   task automatic apply_register(csr_reg_type idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         REG_WINDOW: begin
            if (window_of(v[WIN_REG_W-1:0]) != window_of(win_reg)) wipe_stores();
            win_reg = v[WIN_REG_W-1:0];
         end
         REG_TAU: tau_reg = v;
         REG_SELECT: sel_reg = v[SEL_REG_W-1:0];
         REG_BYPASS: begin
            if (v[0] && !bypass_reg) wipe_stores();
            bypass_reg = v[0];
         end
      endcase
   endtask

   // update the correlation for one accepted item, queue a report if asked
   task automatic predict_item(logic op, logic [15:0] sa, logic [15:0] sb, logic eob);
      int unsigned   n, f, best, worst, sel;
      longint        a_add, a_sub, b_add, b_sub, v;
      longint unsigned peak, mag;
      delay_report_type rep;
      n = window_of(win_reg);
      f = 2 * n;
      if (op) begin
         wipe_stores();
      end else if (!bypass_reg) begin
         a_add = a_ring[ring_back(n)];
         a_sub = a_ring[ring_back(2 * n)];
         for (int i = 0; i < f; i++) begin
            b_add = b_ring[ring_back(2 * n - i)];
            b_sub = b_ring[ring_back(3 * n - i)];
            corr_sum[i] += a_add * b_add - a_sub * b_sub;
            corr_avg[i] += smooth_step(corr_sum[i] - corr_avg[i], longint'(tau_reg));
         end
         a_ring[ring_pos] = longint'($signed(sa));
         b_ring[ring_pos] = longint'($signed(sb));
         ring_pos = (ring_pos + 1) % HIST_LEN;
      end
      if (!eob) return;
      rep = '{default: '0};
      if (!op && !bypass_reg) begin
         best = 0;
         worst = 0;
         peak = 0;
         for (int i = 0; i < f; i++) begin
            v = corr_avg[i];
            mag = (v < 0) ? longint'(-v) : longint'(v);
            if (mag > peak) peak = mag;
            if (v > corr_avg[best]) best = i;
            if (v < corr_avg[worst]) worst = i;
         end
         sel = (sel_reg > f - 1) ? f - 1 : sel_reg;
         rep.best_delay   = DELAY_W'(longint'(n) - longint'(best));
         rep.best_value   = VALUE_W'(scale_to_peak(corr_avg[best], peak));
         rep.worst_delay  = DELAY_W'(longint'(n) - longint'(worst));
         rep.worst_value  = VALUE_W'(scale_to_peak(corr_avg[worst], peak));
         rep.chosen_delay = DELAY_W'(longint'(n) - longint'(sel));
         rep.chosen_value = VALUE_W'(scale_to_peak(corr_avg[sel], peak));
      end
      reports_due.push_back(rep);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // receiver: stall pattern plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // report checker
   always @(posedge clock) begin
      delay_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (reports_due.size() == 0) begin
            $display("[%0t] report with none expected", $realtime);
            error_count++;
         end else begin
            want = reports_due.pop_front();
            if (rsp_chan.best_delay !== want.best_delay)
               report_mismatch("best_delay", rsp_chan.best_delay, want.best_delay);
            if (rsp_chan.best_value !== want.best_value)
               report_mismatch("best_value", rsp_chan.best_value, want.best_value);
            if (rsp_chan.worst_delay !== want.worst_delay)
               report_mismatch("worst_delay", rsp_chan.worst_delay, want.worst_delay);
            if (rsp_chan.worst_value !== want.worst_value)
               report_mismatch("worst_value", rsp_chan.worst_value, want.worst_value);
            if (rsp_chan.chosen_delay !== want.chosen_delay)
               report_mismatch("chosen_delay", rsp_chan.chosen_delay, want.chosen_delay);
            if (rsp_chan.chosen_value !== want.chosen_value)
               report_mismatch("chosen_value", rsp_chan.chosen_value, want.chosen_value);
         end
      end
   end

   // one request transfer, with burst gaps on the way in
   task automatic send_item(logic op, logic [15:0] sa, logic [15:0] sb, logic eob);
      if (burst_left == 0) begin
         int gap;
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.op           <= op;
      req_chan.sample_a     <= sa;
      req_chan.sample_b     <= sb;
      req_chan.end_of_block <= eob;
      do @(posedge clock); while (!req_chan.ready);
      predict_item(op, sa, sb, eob);
   endtask

   task automatic push(logic [15:0] sa, logic [15:0] sb, logic eob);
      send_item(1'b0, sa, sb, eob);
   endtask

   // wait for every pending report, then let the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] v);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= v;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      apply_register(idx, v);
   endtask

   task automatic configure(logic [10:0] w, logic [15:0] tau, logic [10:0] sel);
      write_reg(REG_WINDOW, 16'(w));
      write_reg(REG_TAU, tau);
      write_reg(REG_SELECT, 16'(sel));
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom());
      endcase
   endfunction

   // random pairs: b follows a at a fixed offset plus noise, with rare clears
   task automatic random_pairs(int count, int offset);
      logic [15:0] sa, sb;
      logic        eob, op;
      for (int k = 0; k < count; k++) begin
         sa = pick_sample();
         for (int j = 63; j > 0; j--) a_trail[j] = a_trail[j-1];
         a_trail[0] = sa;
         sb = ($urandom_range(0, 4) == 0) ? pick_sample()
                                          : a_trail[offset] + 16'($urandom_range(0, 511));
         eob = (k == count - 1) || ($urandom_range(0, 4) == 0);
         op  = (k != count - 1) && ($urandom_range(0, 40) == 0);
         send_item(op, sa, sb, eob);
      end
   endtask

   // all-zero stores, extreme samples, clear operation at the reset window
   task automatic test_reset_defaults();
      push(16'h0000, 16'h0000, 1'b1);
      push(16'h7fff, 16'h8000, 1'b0);
      push(16'h8000, 16'h8000, 1'b1);
      push(16'h7fff, 16'h7fff, 1'b1);
      send_item(1'b1, 16'h1234, 16'h4321, 1'b1);
      send_item(1'b1, 16'h0000, 16'h0000, 1'b0);
      push(16'h0001, 16'hffff, 1'b1);
      drain();
   endtask

   // smallest window, full-weight smoothing, selector at both ends
   task automatic test_small_window_extremes();
      configure(11'd5, 16'hffff, 11'd0);
      for (int k = 0; k < 10; k++)
         push((k % 2) ? 16'h7fff : 16'h8000, (k % 3) ? 16'h8000 : 16'h7fff, k % 3 == 2);
      push(16'h4000, 16'hc000, 1'b1);
      drain();
      write_reg(REG_SELECT, 16'd2047);
      push(16'h7fff, 16'h7fff, 1'b1);
      drain();
   endtask

   // bypass holds the stores cleared and zeroes reports
   task automatic test_bypass();
      write_reg(REG_BYPASS, 16'd1);
      push(16'h7fff, 16'h7fff, 1'b0);
      push(16'h8000, 16'h7fff, 1'b1);
      drain();
      write_reg(REG_BYPASS, 16'd0);
      push(16'h7fff, 16'h7fff, 1'b1);
      drain();
   endtask

   // random runs over several window and smoothing settings
   task automatic test_random_windows();
      configure(11'd5, 16'hffff, 11'd3);
      random_pairs(60, 2);
      drain();
      // same effective window: no clear expected
      configure(11'd0, 16'h0000, 11'd7);
      random_pairs(25, 1);
      drain();
      configure(11'd11, 16'($urandom()), 11'd2047);
      random_pairs(55, 5);
      drain();
      configure(11'd2047, 16'd40000, 11'd1023);
      random_pairs(5, 3);
      drain();
   endtask

   // long receiver hold-off so the block backs up into its input
   task automatic test_output_backpressure();
      configure(11'd16, 16'h8000, 11'($urandom_range(0, 31)));
      hold_request = 3000;
      for (int k = 0; k < 20; k++) push(pick_sample(), pick_sample(), 1'b1);
      random_pairs(35, 9);
      drain();
   endtask

   // bypass switched on and off in the middle of random traffic
   task automatic test_bypass_random();
      configure(11'd64, 16'($urandom()), 11'($urandom()));
      random_pairs(25, 12);
      drain();
      write_reg(REG_BYPASS, 16'd1);
      random_pairs(10, 4);
      drain();
      write_reg(REG_BYPASS, 16'd0);
      random_pairs(25, 20);
      drain();
   endtask

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.op           = 1'b0;
      req_chan.sample_a     = '0;
      req_chan.sample_b     = '0;
      req_chan.end_of_block = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = REG_WINDOW;
      csr_chan.data         = '0;
      win_reg    = WIN_RESET;
      tau_reg    = TAU_RESET;
      sel_reg    = SEL_RESET;
      bypass_reg = 1'b0;
      wipe_stores();
      for (int j = 0; j < 64; j++) a_trail[j] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_small_window_extremes();
      test_bypass();
      test_random_windows();
      test_output_backpressure();
      test_bypass_random();
      drain();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
